### hdl/poseiir_pkg.sv
`timescale 1ns / 1ps

package poseiir_pkg;

	localparam int CHANNELS    = 7;
	localparam int SAMPLE_BITS = 24;
	localparam int STATE_BITS  = 40;
	localparam int HALF_BITS   = STATE_BITS / 2;
	localparam int KCOEF_BITS  = 22;
	localparam int OPND_BITS   = SAMPLE_BITS + 3;
	localparam int PROD_BITS   = OPND_BITS + KCOEF_BITS + 1;
	localparam int ACC_BITS    = 68;
	localparam int ROUND_SHIFT = 20;
	localparam int GAIN_SHIFT  = 10;
	localparam int CHAN_BITS   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int STEP_BITS   = 5;

	localparam logic [KCOEF_BITS-1:0] K_G  = KCOEF_BITS'(1159093);
	localparam logic [KCOEF_BITS-1:0] K_A0 = KCOEF_BITS'(674834);
	localparam logic [KCOEF_BITS-1:0] K_A1 = KCOEF_BITS'(2320749);
	localparam logic [KCOEF_BITS-1:0] K_A2 = KCOEF_BITS'(2685435);
	localparam logic [KCOEF_BITS-1:0] K_B0 = KCOEF_BITS'(1037763);
	localparam logic [KCOEF_BITS-1:0] K_B1 = KCOEF_BITS'(2059322);
	localparam logic [KCOEF_BITS-1:0] K_B2 = KCOEF_BITS'(1026949);

	localparam logic [STEP_BITS-1:0] STEP_LP_ROUND = STEP_BITS'(8);
	localparam logic [STEP_BITS-1:0] STEP_LAST     = STEP_BITS'(20);

	typedef logic signed [SAMPLE_BITS-1:0] sample_t;
	typedef logic signed [STATE_BITS-1:0]  hist_t;
	typedef logic signed [ACC_BITS-1:0]    acc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_WRAP
	} state_t;

	typedef enum logic [2:0] {
		SRC_FF,
		SRC_LP0,
		SRC_LP1,
		SRC_LP2,
		SRC_LNEW,
		SRC_NT0,
		SRC_NT1
	} src_t;

	typedef enum logic [1:0] {
		MODE_NONE,
		MODE_FLOOR,
		MODE_LO,
		MODE_HI
	} mode_t;

	typedef struct packed {
		src_t                  src;
		logic [KCOEF_BITS-1:0] coef;
		logic                  neg;
		mode_t                 mode;
	} op_t;

	function automatic op_t step_op(input logic [STEP_BITS-1:0] s);
		op_t o;
		o = '{src: SRC_FF, coef: '0, neg: 1'b0, mode: MODE_NONE};
		case (s)
			5'd0:  o = '{src: SRC_FF,   coef: K_G,  neg: 1'b0, mode: MODE_FLOOR};
			5'd1:  o = '{src: SRC_LP2,  coef: K_A0, neg: 1'b0, mode: MODE_LO};
			5'd2:  o = '{src: SRC_LP2,  coef: K_A0, neg: 1'b0, mode: MODE_HI};
			5'd3:  o = '{src: SRC_LP1,  coef: K_A1, neg: 1'b1, mode: MODE_LO};
			5'd4:  o = '{src: SRC_LP1,  coef: K_A1, neg: 1'b1, mode: MODE_HI};
			5'd5:  o = '{src: SRC_LP0,  coef: K_A2, neg: 1'b0, mode: MODE_LO};
			5'd6:  o = '{src: SRC_LP0,  coef: K_A2, neg: 1'b0, mode: MODE_HI};
			5'd9:  o = '{src: SRC_LNEW, coef: K_B0, neg: 1'b0, mode: MODE_LO};
			5'd10: o = '{src: SRC_LNEW, coef: K_B0, neg: 1'b0, mode: MODE_HI};
			5'd11: o = '{src: SRC_LP0,  coef: K_B1, neg: 1'b1, mode: MODE_LO};
			5'd12: o = '{src: SRC_LP0,  coef: K_B1, neg: 1'b1, mode: MODE_HI};
			5'd13: o = '{src: SRC_LP1,  coef: K_B0, neg: 1'b0, mode: MODE_LO};
			5'd14: o = '{src: SRC_LP1,  coef: K_B0, neg: 1'b0, mode: MODE_HI};
			5'd15: o = '{src: SRC_NT0,  coef: K_B1, neg: 1'b0, mode: MODE_LO};
			5'd16: o = '{src: SRC_NT0,  coef: K_B1, neg: 1'b0, mode: MODE_HI};
			5'd17: o = '{src: SRC_NT1,  coef: K_B2, neg: 1'b1, mode: MODE_LO};
			5'd18: o = '{src: SRC_NT1,  coef: K_B2, neg: 1'b1, mode: MODE_HI};
			default: o = '{src: SRC_FF, coef: '0, neg: 1'b0, mode: MODE_NONE};
		endcase
		return o;
	endfunction

	// round half up from Q.36 to Q.16, then clamp to the history range
	function automatic hist_t round_sat(input acc_t v);
		acc_t r;
		acc_t hmax;
		acc_t hmin;
		hist_t res;
		r    = (v + (acc_t'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
		hmax = (acc_t'(1) <<< (STATE_BITS - 1)) - acc_t'(1);
		hmin = -hmax - acc_t'(1);
		if (r > hmax) begin
			res = hist_t'(hmax);
		end else if (r < hmin) begin
			res = hist_t'(hmin);
		end else begin
			res = hist_t'(r);
		end
		return res;
	endfunction

	function automatic sample_t sat_sample(input hist_t v);
		hist_t smax;
		hist_t smin;
		sample_t res;
		smax = (hist_t'(1) <<< (SAMPLE_BITS - 1)) - hist_t'(1);
		smin = -smax - hist_t'(1);
		if (v > smax) begin
			res = sample_t'(smax);
		end else if (v < smin) begin
			res = sample_t'(smin);
		end else begin
			res = sample_t'(v);
		end
		return res;
	endfunction

endpackage

### hdl/poseiir_in_if.sv
`timescale 1ns / 1ps

interface poseiir_in_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] pos_x_in;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] pos_y_in;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] pos_z_in;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] quat_w_in;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] quat_x_in;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] quat_y_in;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] quat_z_in;

	modport source (
		output valid, pos_x_in, pos_y_in, pos_z_in, quat_w_in, quat_x_in, quat_y_in, quat_z_in,
		input  ready
	);
	modport sink (
		input  valid, pos_x_in, pos_y_in, pos_z_in, quat_w_in, quat_x_in, quat_y_in, quat_z_in,
		output ready
	);
endinterface

### hdl/poseiir_out_if.sv
`timescale 1ns / 1ps

interface poseiir_out_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] pos_x_out;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] pos_y_out;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] pos_z_out;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] quat_w_out;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] quat_x_out;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] quat_y_out;
	logic signed [poseiir_pkg::SAMPLE_BITS-1:0] quat_z_out;

	modport source (
		output valid, pos_x_out, pos_y_out, pos_z_out,
		output quat_w_out, quat_x_out, quat_y_out, quat_z_out,
		input  ready
	);
	modport sink (
		input  valid, pos_x_out, pos_y_out, pos_z_out,
		input  quat_w_out, quat_x_out, quat_y_out, quat_z_out,
		output ready
	);
endinterface

### hdl/pose_lowpass_notch_iir_filter_core.sv
`timescale 1ns / 1ps
// Pose smoothing filter: seven channels, each a third-order low-pass IIR
// followed by a biquad notch that shares the low-pass output history.
// samples:  valid/ready channel, one word = seven signed Q8.16 samples.
// filtered: valid/ready channel, one word = seven saturated Q8.16 results.
// A word is taken only when the core is idle. One 27x23 multiplier and one
// 68-bit accumulator do all the work under a step counter: each channel
// runs 17 products, then drain and rounding steps; after the last
// channel the result is loaded into the output register, and only after
// that load is the next word accepted.
// 40-bit history values enter the multiplier as two 20-bit halves, which
// sets the product count.
// The result sits in an output register; the next sample word is accepted
// while it waits. If the receiver still stalls when the next result is done,
// the core holds that result and accepts nothing until the register frees.
// Reset clears all filter histories to zero and empties the output register.
module pose_lowpass_notch_iir_filter_core (
	input  logic                 clk,
	input  logic                 arst_n,
	poseiir_in_if.sink           samples,
	poseiir_out_if.source        filtered
);
	import poseiir_pkg::*;

	state_t                 state_q, state_d;
	logic [STEP_BITS-1:0]   step_q, step_d;
	logic [CHAN_BITS-1:0]   chan_q, chan_d;
	logic                   accept;
	logic                   hist_we;
	logic                   out_load;
	logic                   out_valid_q;

	sample_t                x_q   [CHANNELS];
	sample_t                xr0_q [CHANNELS];
	sample_t                xr1_q [CHANNELS];
	sample_t                xr2_q [CHANNELS];
	hist_t                  lp0_q [CHANNELS];
	hist_t                  lp1_q [CHANNELS];
	hist_t                  lp2_q [CHANNELS];
	hist_t                  nt0_q [CHANNELS];
	hist_t                  nt1_q [CHANNELS];
	sample_t                res_q [CHANNELS];
	sample_t                out_q [CHANNELS];

	hist_t                  lnew_q;
	acc_t                   acc_q;
	logic signed [PROD_BITS-1:0] prod_q;
	mode_t                  mode_q;
	logic                   neg_q;

	op_t                    op;
	logic signed [OPND_BITS-1:0] ff;
	logic signed [OPND_BITS-1:0] opnd;
	hist_t                  hsel;
	acc_t                   t_full;
	acc_t                   term;
	hist_t                  rnd;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			chan_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			chan_q  <= chan_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		step_d        = step_q;
		chan_d        = chan_q;
		samples.ready = 1'b0;
		accept        = 1'b0;
		hist_we       = 1'b0;
		out_load      = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				samples.ready = 1'b1;
				if (samples.valid) begin
					accept  = 1'b1;
					state_d = ST_RUN;
					step_d  = '0;
					chan_d  = '0;
				end
			end
			ST_RUN: begin
				if (step_q == STEP_LAST) begin
					hist_we = 1'b1;
					step_d  = '0;
					if (chan_q == CHAN_BITS'(CHANNELS - 1)) begin
						state_d = ST_WRAP;
					end else begin
						chan_d = chan_q + 1'b1;
					end
				end else begin
					step_d = step_q + 1'b1;
				end
			end
			ST_WRAP: begin
				if (!out_valid_q || filtered.ready) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// operand select for the shared multiplier
	assign op = step_op(step_q);

	always_comb begin
		ff = OPND_BITS'(x_q[chan_q]) + OPND_BITS'(xr2_q[chan_q])
		   + (OPND_BITS'(xr0_q[chan_q]) <<< 1) + OPND_BITS'(xr0_q[chan_q])
		   + (OPND_BITS'(xr1_q[chan_q]) <<< 1) + OPND_BITS'(xr1_q[chan_q]);
		unique case (op.src)
			SRC_LP0:  hsel = lp0_q[chan_q];
			SRC_LP1:  hsel = lp1_q[chan_q];
			SRC_LP2:  hsel = lp2_q[chan_q];
			SRC_LNEW: hsel = lnew_q;
			SRC_NT0:  hsel = nt0_q[chan_q];
			SRC_NT1:  hsel = nt1_q[chan_q];
			default:  hsel = '0;
		endcase
		unique case (op.mode)
			MODE_FLOOR: opnd = ff;
			MODE_LO:    opnd = OPND_BITS'({1'b0, hsel[HALF_BITS-1:0]});
			MODE_HI:    opnd = OPND_BITS'($signed(hsel[STATE_BITS-1:HALF_BITS]));
			default:    opnd = '0;
		endcase
	end

	always_comb begin
		unique case (mode_q)
			MODE_FLOOR: t_full = acc_t'(prod_q) >>> GAIN_SHIFT;
			MODE_LO:    t_full = acc_t'(prod_q);
			MODE_HI:    t_full = acc_t'(prod_q) <<< HALF_BITS;
			default:    t_full = '0;
		endcase
		term = neg_q ? -t_full : t_full;
		rnd  = round_sat(acc_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NONE;
			neg_q  <= 1'b0;
		end else begin
			mode_q <= (state_q == ST_RUN) ? op.mode : MODE_NONE;
			neg_q  <= op.neg;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= PROD_BITS'(opnd) * $signed({{(PROD_BITS - KCOEF_BITS){1'b0}}, op.coef});
		if (accept || (state_q == ST_RUN && (step_q == STEP_LP_ROUND || step_q == STEP_LAST))) begin
			acc_q <= '0;
		end else if (mode_q != MODE_NONE) begin
			acc_q <= acc_q + term;
		end
		if (state_q == ST_RUN && step_q == STEP_LP_ROUND) begin
			lnew_q <= rnd;
		end
		if (accept) begin
			x_q[0] <= samples.pos_x_in;
			x_q[1] <= samples.pos_y_in;
			x_q[2] <= samples.pos_z_in;
			x_q[3] <= samples.quat_w_in;
			x_q[4] <= samples.quat_x_in;
			x_q[5] <= samples.quat_y_in;
			x_q[6] <= samples.quat_z_in;
		end
		if (hist_we) begin
			res_q[chan_q] <= sat_sample(rnd);
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				xr0_q[c] <= '0;
				xr1_q[c] <= '0;
				xr2_q[c] <= '0;
				lp0_q[c] <= '0;
				lp1_q[c] <= '0;
				lp2_q[c] <= '0;
				nt0_q[c] <= '0;
				nt1_q[c] <= '0;
			end
		end else if (hist_we) begin
			xr2_q[chan_q] <= xr1_q[chan_q];
			xr1_q[chan_q] <= xr0_q[chan_q];
			xr0_q[chan_q] <= x_q[chan_q];
			lp2_q[chan_q] <= lp1_q[chan_q];
			lp1_q[chan_q] <= lp0_q[chan_q];
			lp0_q[chan_q] <= lnew_q;
			nt1_q[chan_q] <= nt0_q[chan_q];
			nt0_q[chan_q] <= rnd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (filtered.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign filtered.valid      = out_valid_q;
	assign filtered.pos_x_out  = out_q[0];
	assign filtered.pos_y_out  = out_q[1];
	assign filtered.pos_z_out  = out_q[2];
	assign filtered.quat_w_out = out_q[3];
	assign filtered.quat_x_out = out_q[4];
	assign filtered.quat_y_out = out_q[5];
	assign filtered.quat_z_out = out_q[6];

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_LAST)
		else $error("step counter out of range");

	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		(samples.valid && samples.ready) |=> (state_q == ST_RUN && step_q == '0 && chan_q == '0))
		else $error("accepted word did not start at channel zero");

	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN && step_q == STEP_LAST && chan_q == CHAN_BITS'(CHANNELS - 1))
		|=> (state_q == ST_WRAP))
		else $error("last channel did not finish the word");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WRAP && filtered.valid && !filtered.ready) |=> (state_q == ST_WRAP))
		else $error("pending result overwritten");

endmodule

### dv/pose_sb_pkg.sv
`timescale 1ns / 1ps

package pose_sb_pkg;

	import poseiir_pkg::*;

	typedef logic [CHANNELS-1:0][SAMPLE_BITS-1:0] pose_word_t;

	localparam longint GAIN_Q30 = longint'(K_G);
	localparam longint LP_A0    = longint'(K_A0);
	localparam longint LP_A1    = longint'(K_A1);
	localparam longint LP_A2    = longint'(K_A2);
	localparam longint NT_B0    = longint'(K_B0);
	localparam longint NT_B1    = longint'(K_B1);
	localparam longint NT_B2    = longint'(K_B2);

	localparam longint HIST_MAX   = (longint'(1) <<< (STATE_BITS - 1)) - 1;
	localparam longint HIST_MIN   = -HIST_MAX - 1;
	localparam longint SAMPLE_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
	localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;

	class pose_scoreboard;
		sample_t    raw_hist [CHANNELS][3];
		hist_t      lp_hist  [CHANNELS][3];
		hist_t      nt_hist  [CHANNELS][2];
		pose_word_t expected_q [$];
		int         errors;
		int         words_in;
		int         words_checked;
		int         rail_hits;

		function new();
			foreach (raw_hist[c, k]) begin
				raw_hist[c][k] = '0;
				lp_hist[c][k]  = '0;
			end
			foreach (nt_hist[c, k]) begin
				nt_hist[c][k] = '0;
			end
			errors        = 0;
			words_in      = 0;
			words_checked = 0;
			rail_hits     = 0;
		endfunction

		// Q.36 -> Q.16, round half up, clamp to the 40-bit history range
		static function hist_t round_clamp(input longint acc);
			longint r;
			r = (acc + (longint'(1) <<< (ROUND_SHIFT - 1))) >>> ROUND_SHIFT;
			if (r > HIST_MAX) begin
				r = HIST_MAX;
			end else if (r < HIST_MIN) begin
				r = HIST_MIN;
			end
			return hist_t'(r);
		endfunction

		static function string chan_name(input int c);
			case (c)
				0: return "pos_x_out";
				1: return "pos_y_out";
				2: return "pos_z_out";
				3: return "quat_w_out";
				4: return "quat_x_out";
				5: return "quat_y_out";
				default: return "quat_z_out";
			endcase
		endfunction

		function void note_sample_word(input pose_word_t w);
			pose_word_t res;
			longint     x;
			longint     ff;
			longint     acc;
			longint     lp0;
			longint     lp1;
			longint     lp2;
			longint     nw;
			hist_t      lnew;
			hist_t      nnew;
			for (int c = 0; c < CHANNELS; c++) begin
				x   = longint'(sample_t'(w[c]));
				lp0 = longint'(lp_hist[c][0]);
				lp1 = longint'(lp_hist[c][1]);
				lp2 = longint'(lp_hist[c][2]);
				ff  = x + 3 * longint'(raw_hist[c][0]) + 3 * longint'(raw_hist[c][1])
					+ longint'(raw_hist[c][2]);
				acc = (ff * GAIN_Q30) >>> GAIN_SHIFT;
				acc += LP_A0 * lp2 - LP_A1 * lp1 + LP_A2 * lp0;
				lnew = round_clamp(acc);

				// notch input history is the low-pass output history
				acc = NT_B0 * longint'(lnew) - NT_B1 * lp0 + NT_B0 * lp1
					+ NT_B1 * longint'(nt_hist[c][0]) - NT_B2 * longint'(nt_hist[c][1]);
				nnew = round_clamp(acc);

				raw_hist[c][2] = raw_hist[c][1];
				raw_hist[c][1] = raw_hist[c][0];
				raw_hist[c][0] = sample_t'(w[c]);
				lp_hist[c][2]  = lp_hist[c][1];
				lp_hist[c][1]  = lp_hist[c][0];
				lp_hist[c][0]  = lnew;
				nt_hist[c][1]  = nt_hist[c][0];
				nt_hist[c][0]  = nnew;

				nw = longint'(nnew);
				if (nw > SAMPLE_MAX) begin
					nw = SAMPLE_MAX;
					rail_hits++;
				end else if (nw < SAMPLE_MIN) begin
					nw = SAMPLE_MIN;
					rail_hits++;
				end
				res[c] = SAMPLE_BITS'(nw);
			end
			expected_q.push_back(res);
			words_in++;
		endfunction

		function void check_filtered_word(input pose_word_t got);
			pose_word_t want;
			if (expected_q.size() == 0) begin
				$error("filtered word with no sample word outstanding");
				errors++;
				return;
			end
			want = expected_q.pop_front();
			words_checked++;
			for (int c = 0; c < CHANNELS; c++) begin
				if (got[c] !== want[c]) begin
					$error("%s: expected %0d, actual %0d", chan_name(c),
						$signed(want[c]), $signed(got[c]));
					errors++;
				end
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

endpackage

### dv/pose_lowpass_notch_iir_filter_core_tb.sv
`timescale 1ns / 1ps

module pose_lowpass_notch_iir_filter_core_tb;

	import poseiir_pkg::*;
	import pose_sb_pkg::*;

	localparam int PHASE_WORDS  = 500;
	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 300;

	localparam sample_t SAMPLE_HI = 24'sh7FFFFF;
	localparam sample_t SAMPLE_LO = 24'sh800000;

	typedef enum int {
		SEG_NOISE,
		SEG_HOLD,
		SEG_WALK
	} seg_kind_t;

	logic clk;
	logic arst_n;
	int   idle_pct  = 0;
	int   stall_pct = 0;

	seg_kind_t seg_kind  [CHANNELS];
	int        seg_left  [CHANNELS];
	sample_t   seg_level [CHANNELS];

	pose_scoreboard sb = new();

	poseiir_in_if  samples_if ();
	poseiir_out_if filtered_if ();

	pose_lowpass_notch_iir_filter_core u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples_if),
		.filtered (filtered_if)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	always @(negedge clk) begin
		filtered_if.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		if (samples_if.valid && samples_if.ready) begin
			sb.note_sample_word({samples_if.quat_z_in, samples_if.quat_y_in,
				samples_if.quat_x_in, samples_if.quat_w_in, samples_if.pos_z_in,
				samples_if.pos_y_in, samples_if.pos_x_in});
		end
		if (filtered_if.valid && filtered_if.ready) begin
			sb.check_filtered_word({filtered_if.quat_z_out, filtered_if.quat_y_out,
				filtered_if.quat_x_out, filtered_if.quat_w_out, filtered_if.pos_z_out,
				filtered_if.pos_y_out, filtered_if.pos_x_out});
		end
	end

	task automatic send_word(input pose_word_t w);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			samples_if.valid <= 1'b0;
			@(negedge clk);
		end
		samples_if.valid     <= 1'b1;
		samples_if.pos_x_in  <= w[0];
		samples_if.pos_y_in  <= w[1];
		samples_if.pos_z_in  <= w[2];
		samples_if.quat_w_in <= w[3];
		samples_if.quat_x_in <= w[4];
		samples_if.quat_y_in <= w[5];
		samples_if.quat_z_in <= w[6];
		do begin
			@(posedge clk);
		end while (!samples_if.ready);
	endtask

	// per channel: held levels (step responses), random walks, and plain noise
	task automatic run_phase(input int idle, input int stall, input int words);
		pose_word_t w;
		idle_pct  = idle;
		stall_pct = stall;
		repeat (words) begin
			for (int c = 0; c < CHANNELS; c++) begin
				if (seg_left[c] == 0) begin
					seg_kind[c] = seg_kind_t'($urandom_range(2));
					seg_left[c] = $urandom_range(4, 60);
					case ($urandom_range(3))
						0: seg_level[c] = SAMPLE_HI;
						1: seg_level[c] = SAMPLE_LO;
						default: seg_level[c] = SAMPLE_BITS'($urandom);
					endcase
				end
				seg_left[c]--;
				case (seg_kind[c])
					SEG_NOISE: begin
						w[c] = SAMPLE_BITS'($urandom);
					end
					SEG_HOLD: begin
						w[c] = seg_level[c];
					end
					default: begin
						seg_level[c] = seg_level[c] + sample_t'($urandom_range(8191))
							- sample_t'(4096);
						w[c] = seg_level[c];
					end
				endcase
			end
			send_word(w);
		end
	endtask

	initial begin
		arst_n               = 1'b0;
		filtered_if.ready    = 1'b0;
		samples_if.valid     = 1'b0;
		samples_if.pos_x_in  = '0;
		samples_if.pos_y_in  = '0;
		samples_if.pos_z_in  = '0;
		samples_if.quat_w_in = '0;
		samples_if.quat_x_in = '0;
		samples_if.quat_y_in = '0;
		samples_if.quat_z_in = '0;
		foreach (seg_left[c]) begin
			seg_left[c] = 0;
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;

		// directed: zero, full-scale steps both ways, alternating rails, bit patterns
		send_word('0);
		repeat (8) send_word({CHANNELS{SAMPLE_HI}});
		repeat (8) send_word({CHANNELS{SAMPLE_LO}});
		send_word({SAMPLE_HI, SAMPLE_LO, SAMPLE_HI, SAMPLE_LO, SAMPLE_HI, SAMPLE_LO, SAMPLE_HI});
		send_word({SAMPLE_LO, SAMPLE_HI, SAMPLE_LO, SAMPLE_HI, SAMPLE_LO, SAMPLE_HI, SAMPLE_LO});
		send_word({CHANNELS{24'h555555}});
		send_word({CHANNELS{24'hAAAAAA}});
		send_word({CHANNELS{24'hFFFFFF}});
		send_word({CHANNELS{24'h000001}});

		run_phase(0, 0, PHASE_WORDS);
		run_phase(58, 0, PHASE_WORDS);
		run_phase(0, 58, PHASE_WORDS);
		run_phase(33, 33, PHASE_WORDS);

		@(negedge clk);
		samples_if.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Fed %0d pose words (directed rails and patterns, then steps, ramps, noise)",
			sb.words_in);
		$display("under four idle/stall mixes; %0d filtered words checked, %0d outputs clamped.",
			sb.words_checked, sb.rail_hits);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((samples_if.valid && samples_if.ready)
				|| (filtered_if.valid && filtered_if.ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$error("no word moved for %0d cycles", QUIET_LIMIT);
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

### files.f
hdl/poseiir_pkg.sv
hdl/poseiir_in_if.sv
hdl/poseiir_out_if.sv
hdl/pose_lowpass_notch_iir_filter_core.sv
dv/pose_sb_pkg.sv
dv/pose_lowpass_notch_iir_filter_core_tb.sv
